// File: design/stj_pkg.sv
// ----------------------------------------------------------------------------
// stj_pkg
// Shared types, constants and the siphash round for the short txid unit.
// ----------------------------------------------------------------------------
package stj_pkg;

    localparam int WORD_W    = 64;
    localparam int MSG_WORDS = 4;
    localparam int MSG_W     = WORD_W * MSG_WORDS;
    localparam int OUT_W     = 48;
    localparam int ROUNDS    = 14;
    localparam int ABS_RNDS  = 10;
    localparam int IDX_W     = 8;

    localparam logic [WORD_W-1:0] SIP_INIT0     = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_INIT1     = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_INIT2     = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_INIT3     = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;
    localparam logic [WORD_W-1:0] SIP_LEN_BLOCK = 64'h2000000000000000;

    localparam logic [IDX_W-1:0] CFG_KEY_LOW  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_KEY_HIGH = 8'd1;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } lanes_t;

    // xor masks applied around one round
    typedef struct packed {
        logic [WORD_W-1:0] pre_c;
        logic [WORD_W-1:0] pre_d;
        logic [WORD_W-1:0] post_a;
    } round_mix_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        logic [2*WORD_W-1:0] w;
        w = {x, x} << n;
        return w[2*WORD_W-1:WORD_W];
    endfunction

    function automatic lanes_t sip_round(input lanes_t s);
        lanes_t r;
        r = s;
        r.a = r.a + r.b; r.b = rotl(r.b, 13); r.b = r.b ^ r.a; r.a = rotl(r.a, 32);
        r.c = r.c + r.d; r.d = rotl(r.d, 16); r.d = r.d ^ r.c;
        r.a = r.a + r.d; r.d = rotl(r.d, 21); r.d = r.d ^ r.a;
        r.c = r.c + r.b; r.b = rotl(r.b, 17); r.b = r.b ^ r.c; r.c = rotl(r.c, 32);
        return r;
    endfunction

endpackage

// File: design/stj_round_stage.sv
// ----------------------------------------------------------------------------
// stj_round_stage
// One pipeline stage: xors in its masks (a message word, the final constant
// or none), runs one siphash round and registers lanes and message words.
// ----------------------------------------------------------------------------
module stj_round_stage
    import stj_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  lanes_t           in_lanes,
    input  logic [MSG_W-1:0] in_msg,
    input  round_mix_t       mix,
    output logic             out_valid,
    input  logic             out_ready,
    output lanes_t           out_lanes,
    output logic [MSG_W-1:0] out_msg
);

    logic             valid_reg;
    lanes_t           lanes_reg;
    lanes_t           lanes_next;
    logic [MSG_W-1:0] msg_reg;
    lanes_t           pre;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        pre        = in_lanes;
        pre.c      = in_lanes.c ^ mix.pre_c;
        pre.d      = in_lanes.d ^ mix.pre_d;
        lanes_next = sip_round(pre);
        lanes_next.a = lanes_next.a ^ mix.post_a;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            lanes_reg <= lanes_next;
            msg_reg   <= in_msg;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;
    assign out_msg   = msg_reg;

endmodule

// File: design/short_txid_siphash_unit.sv
// ----------------------------------------------------------------------------
// short_txid_siphash_unit
// SipHash-2-4 short transaction id: 32-byte hash in, 48-bit id out.
//
// channel  dir  width  content
// s_       in   256    hash words 0..3
// m_       out  48     short id
// cfg_     in   64     key word, index 0 = k0, index 1 = k1
//
// one word accepted per cycle while the output is not stalled; 14 round
// stages and one output register, one siphash round per stage
// synchronous active-low reset empties the pipeline and clears both keys
// a stalled output holds; each stage takes a word when it is empty or
// its successor moves, so bubbles close up
// ----------------------------------------------------------------------------
module short_txid_siphash_unit
    import stj_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [MSG_W-1:0]  s_tdata,   // hash_word0, hash_word1, hash_word2, hash_word3
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // txid_tag
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0] cfg_data
);

    logic [WORD_W-1:0] key_low_reg;
    logic [WORD_W-1:0] key_high_reg;

    logic             st_valid [ROUNDS+1];
    logic             st_ready [ROUNDS+1];
    lanes_t           st_lanes [ROUNDS+1];
    logic [MSG_W-1:0] st_msg   [ROUNDS+1];

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;
    logic             out_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // initial lanes from the keys
    assign st_valid[0]   = s_tvalid;
    assign s_tready      = st_ready[0];
    assign st_msg[0]     = s_tdata;
    assign st_lanes[0].a = SIP_INIT0 ^ key_low_reg;
    assign st_lanes[0].b = SIP_INIT1 ^ key_high_reg;
    assign st_lanes[0].c = SIP_INIT2 ^ key_low_reg;
    assign st_lanes[0].d = SIP_INIT3 ^ key_high_reg;

    for (genvar k = 0; k < ROUNDS; k++) begin : g_round
        localparam int W = k / 2;
        logic [WORD_W-1:0] word;
        round_mix_t        mix;

        if (W < MSG_WORDS) begin : g_msg
            assign word = st_msg[k][WORD_W*W +: WORD_W];
        end else begin : g_len
            assign word = SIP_LEN_BLOCK;
        end

        assign mix.pre_d  = (k < ABS_RNDS && (k % 2) == 0) ? word : '0;
        assign mix.post_a = (k < ABS_RNDS && (k % 2) == 1) ? word : '0;
        assign mix.pre_c  = (k == ABS_RNDS) ? SIP_FINAL_XOR : '0;

        stj_round_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_lanes  (st_lanes[k]),
            .in_msg    (st_msg[k]),
            .mix       (mix),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_lanes (st_lanes[k+1]),
            .out_msg   (st_msg[k+1])
        );
    end

    // fold and output register
    assign out_ready     = !out_valid_reg || m_tready;
    assign st_ready[ROUNDS] = out_ready;
    assign out_data_next = OUT_W'(st_lanes[ROUNDS].a ^ st_lanes[ROUNDS].b
                                ^ st_lanes[ROUNDS].c ^ st_lanes[ROUNDS].d);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= st_valid[ROUNDS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && st_valid[ROUNDS]) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_accept_fills_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> st_valid[1])
        else $error("accepted word missing from first stage");

    a_last_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && st_valid[ROUNDS]) |=> st_valid[ROUNDS])
        else $error("last round stage dropped a word under stall");

endmodule

// File: tb/sv/short_txid_siphash_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// short_txid_siphash_unit_tb
// Streams 256-bit transaction hashes through the short txid unit under
// several key settings: the reset keys, both-zero and all-ones keys,
// one-sided keys, random keys and ignored writes to unused register indexes.
// A local SipHash-2-4 model predicts each 48-bit id when a hash word is
// accepted, and the output monitor checks the ids in order. The sender works
// in bursts with random gaps and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module short_txid_siphash_unit_tb
    import stj_pkg::*;
();

    localparam int           HALF_PERIOD  = 4;
    localparam int           RESET_CYCLES = 9;
    localparam int           SETTLE_TICKS = 24;
    localparam int           CYCLE_LIMIT  = 600000;
    localparam int           RANDOM_HASHES = 1880;
    localparam int           PRINT_LIMIT  = 30;

    localparam logic [WORD_W-1:0] IV0      = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] IV1      = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] IV2      = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] IV3      = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] TAIL_LEN = 64'd32 << 56;
    localparam logic [WORD_W-1:0] FIN_MASK = 64'hff;

    typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_CHOKED} rx_mode_t;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } sip_v_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [MSG_W-1:0]  s_tdata   = '0;   // hash_word0, hash_word1, hash_word2, hash_word3
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;          // txid_tag
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0] cfg_data  = '0;

    logic [MSG_W-1:0]  hash_backlog[$];
    logic [OUT_W-1:0]  txid_tag_due[$];
    logic [WORD_W-1:0] k0_shadow = '0;
    logic [WORD_W-1:0] k1_shadow = '0;
    int                fail_count = 0;
    int                cycle_count = 0;
    int                gap_left = 0;
    int                burst_left = 0;
    int                rx_span = 0;
    rx_mode_t          rx_mode = RX_OPEN;

    short_txid_siphash_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // siphash-2-4 tag model
    function automatic logic [WORD_W-1:0] rol64(input logic [WORD_W-1:0] x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic sip_v_t sip_mix(input sip_v_t s);
        sip_v_t t;
        t = s;
        t.v0 = t.v0 + t.v1; t.v1 = rol64(t.v1, 13); t.v1 = t.v1 ^ t.v0;
        t.v0 = rol64(t.v0, 32);
        t.v2 = t.v2 + t.v3; t.v3 = rol64(t.v3, 16); t.v3 = t.v3 ^ t.v2;
        t.v0 = t.v0 + t.v3; t.v3 = rol64(t.v3, 21); t.v3 = t.v3 ^ t.v0;
        t.v2 = t.v2 + t.v1; t.v1 = rol64(t.v1, 17); t.v1 = t.v1 ^ t.v2;
        t.v2 = rol64(t.v2, 32);
        return t;
    endfunction

    function automatic sip_v_t sip_absorb(input sip_v_t s, input logic [WORD_W-1:0] m);
        sip_v_t t;
        t = s;
        t.v3 = t.v3 ^ m;
        t = sip_mix(sip_mix(t));
        t.v0 = t.v0 ^ m;
        return t;
    endfunction

    function automatic logic [OUT_W-1:0] txid_tag_of(input logic [MSG_W-1:0] hash,
                                                     input logic [WORD_W-1:0] k0,
                                                     input logic [WORD_W-1:0] k1);
        sip_v_t            s;
        logic [WORD_W-1:0] h;
        s.v0 = IV0 ^ k0;
        s.v1 = IV1 ^ k1;
        s.v2 = IV2 ^ k0;
        s.v3 = IV3 ^ k1;
        for (int i = 0; i < MSG_WORDS; i++) begin
            s = sip_absorb(s, hash[i*WORD_W +: WORD_W]);
        end
        s = sip_absorb(s, TAIL_LEN);
        s.v2 = s.v2 ^ FIN_MASK;
        for (int i = 0; i < 4; i++) begin
            s = sip_mix(s);
        end
        h = s.v0 ^ s.v1 ^ s.v2 ^ s.v3;
        return h[OUT_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, WORD_W - 1);
            3: return ~(64'd1 << $urandom_range(0, WORD_W - 1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        if (fail_count < PRINT_LIMIT) begin
            $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_stray();
        write_reg(IDX_W'($urandom_range(CFG_KEY_HIGH + 1, (1 << IDX_W) - 1)), rand_word());
    endtask

    task automatic queue_hash(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                              input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3);
        hash_backlog.push_back({w3, w2, w1, w0});
    endtask

    // wait until every queued word has left and every id has come back
    task automatic settle();
        @(posedge aclk);
        while (hash_backlog.size() != 0 || s_tvalid || txid_tag_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // sender: bursts with random gaps, some stretches back to back
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left == 0 && hash_backlog.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= hash_backlog.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1, 2: gap_left = $urandom_range(1, 4);
                        default: gap_left = $urandom_range(5, 24);
                    endcase
                end
            end else begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_span = $urandom_range(8, 80);
            end else begin
                rx_span--;
            end
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                default:   m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // prediction on accepted words, key shadow on register writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                txid_tag_due.push_back(txid_tag_of(s_tdata, k0_shadow, k1_shadow));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_KEY_LOW:  k0_shadow = cfg_data;
                    CFG_KEY_HIGH: k1_shadow = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (txid_tag_due.size() == 0) begin
                report_mismatch("unexpected txid tag", m_tdata, '0);
            end else if (m_tdata !== txid_tag_due[0]) begin
                report_mismatch("txid tag mismatch", m_tdata, txid_tag_due.pop_front());
            end else begin
                void'(txid_tag_due.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int left;
        int n;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset keys, never written
        queue_hash('0, '0, '0, '0);
        queue_hash('1, '1, '1, '1);
        queue_hash({16{4'h5}}, {16{4'ha}}, {16{4'h5}}, {16{4'ha}});
        queue_hash('1, '0, '0, '0);
        queue_hash('0, '1, '0, '0);
        queue_hash('0, '0, '1, '0);
        queue_hash('0, '0, '0, '1);
        queue_hash(64'h8000000000000001, 64'h0123456789abcdef, 64'hfedcba9876543210,
                   64'h7fffffffffffffff);
        settle();

        // unused indexes leave the keys alone
        write_stray();
        write_reg('1, '1);
        queue_hash('0, '0, '0, '0);
        queue_hash({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom});
        settle();

        write_reg(CFG_KEY_LOW, '1);
        queue_hash('0, '0, '0, '0);
        queue_hash('1, '1, '1, '1);
        queue_hash(rand_word(), rand_word(), rand_word(), rand_word());
        settle();

        write_reg(CFG_KEY_LOW, '0);
        write_reg(CFG_KEY_HIGH, '1);
        queue_hash('0, '0, '0, '0);
        queue_hash('1, '1, '1, '1);
        queue_hash(rand_word(), rand_word(), rand_word(), rand_word());
        settle();

        write_reg(CFG_KEY_LOW, '1);
        queue_hash('0, '0, '0, '0);
        queue_hash('1, '1, '1, '1);
        settle();

        // random phases under changing keys
        left = RANDOM_HASHES;
        while (left > 0) begin
            case ($urandom_range(0, 5))
                0: write_reg(CFG_KEY_LOW, rand_word());
                1: write_reg(CFG_KEY_HIGH, rand_word());
                2: begin
                    write_reg(CFG_KEY_LOW, $urandom_range(0, 1) ? '1 : '0);
                    write_reg(CFG_KEY_HIGH, $urandom_range(0, 1) ? '1 : '0);
                end
                default: begin
                    write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
                    write_reg(CFG_KEY_LOW, {$urandom, $urandom});
                end
            endcase
            if ($urandom_range(0, 5) == 0) write_stray();
            n = $urandom_range(40, 240);
            if (n > left) n = left;
            for (int i = 0; i < n; i++) begin
                queue_hash(rand_word(), rand_word(), rand_word(), rand_word());
            end
            left -= n;
            settle();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: short_txid_siphash_unit.f
design/stj_pkg.sv
design/stj_round_stage.sv
design/short_txid_siphash_unit.sv
tb/sv/short_txid_siphash_unit_tb.sv
